// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

    // Widths of the stream fields.
    localparam int REQ_W       = 12;
    localparam int ADDR_W      = 10;
    localparam int NEED_W      = 13;   // request rounded up to 4 bytes
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    // Bit positions inside the slave-side tdata.
    localparam int REQ_LSB     = 0;
    localparam int ADDR_LSB    = 12;

    // Command codes carried in the slave-side tuser.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// An allocate walks the free list one block per read and takes the first block that fits,
// splitting off the tail as a new free block when it is large enough; a free pushes the block
// at the list head, then walks on from it and merges each adjacent successor; a free with a bad
// address is rejected without a walk. A result still waiting in the output register stalls the
// next result. One request is handled at a time; s_tready rises together with m_tvalid.
// Reset (rst_n, asynchronous, active low) empties the output, points the list head at word 0
// and makes word 0 read as one free block spanning the heap less one header; no clearing pass.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: request_size[11:0], block_address[21:12], zero fill.
    input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: command.
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: result_address[9:0], zero fill.
    output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0 up: success.
    output logic [0:0]                      m_tuser
);

    // The heap is viewed as four-byte words. A free block is named by the word index of
    // its header, and HEAP_WORDS itself is the null link.
    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int WW         = AW + 1;
    localparam int SW         = $clog2(HEAP_BYTES);
    localparam int XW         = $clog2(HEAP_BYTES) + 14;
    localparam int WALK_LIMIT = 2 * HEAP_WORDS + 2;
    localparam int CW         = $clog2(WALK_LIMIT + 1);

    localparam logic [WW-1:0] NULL_LINK  = WW'(HEAP_WORDS);
    localparam logic [SW-1:0] SIZE_RESET = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [XW-1:0] SIZE_MAX_X = XW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [XW-1:0] HDR_X      = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] WORDS_X    = XW'(HEAP_WORDS);
    localparam logic [XW-1:0] MIN_TAIL_X = XW'(HEADER_BYTES + 4);
    localparam logic [CW-1:0] CNT_LIMIT  = CW'(WALK_LIMIT);
    localparam logic [ffha_pkg::ADDR_W-1:0] HDR_A = ffha_pkg::ADDR_W'(HEADER_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_READ,
        ST_A_EVAL,
        ST_A_SPLIT,
        ST_F_PUSH,
        ST_F_READ,
        ST_F_EVAL,
        ST_F_MERGE,
        ST_RESP
    } state_t;

    // Sequencer registers.
    state_t                        state_reg,     state_next;
    logic [WW-1:0]                 cur_reg,       cur_next;
    logic [WW-1:0]                 prev_reg,      prev_next;
    logic [WW-1:0]                 head_reg,      head_next;
    logic [WW-1:0]                 split_reg,     split_next;
    logic [CW-1:0]                 cnt_reg,       cnt_next;
    logic [ffha_pkg::NEED_W-1:0]   need_reg,      need_next;
    logic [SW-1:0]                 hold_size_reg, hold_size_next;
    logic [ffha_pkg::ADDR_W-1:0]   res_addr_reg,  res_addr_next;
    logic                          res_ok_reg,    res_ok_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ffha_pkg::ADDR_W-1:0]   out_addr_reg,  out_addr_next;
    logic                          out_ok_reg,    out_ok_next;
    logic                          size0_ok_reg,  size0_ok_next;
    logic                          link0_ok_reg,  link0_ok_next;

    // Header stores: one registered read port shared by both, one write port each.
    logic [SW-1:0] size_mem [HEAP_WORDS];
    logic [WW-1:0] link_mem [HEAP_WORDS];
    logic [SW-1:0] size_q_reg;
    logic [WW-1:0] link_q_reg;
    logic          size_def_reg;
    logic          link_def_reg;

    logic [AW-1:0] rd_idx;
    logic          size_we;
    logic [AW-1:0] size_wa;
    logic [SW-1:0] size_wd;
    logic          link_we;
    logic [AW-1:0] link_wa;
    logic [WW-1:0] link_wd;

    logic [SW-1:0] size_rd;
    logic [WW-1:0] link_rd;

    // Shared datapath terms.
    logic [XW-1:0] have_x;
    logic [XW-1:0] need_x;
    logic [XW-1:0] hdr_addr_x;
    logic [XW-1:0] split_byte_x;
    logic [XW-1:0] split_word_x;
    logic [XW-1:0] end_byte_x;
    logic [XW-1:0] merge_sum_x;
    logic          fits;
    logic          can_split;

    // Free request decode.
    logic [ffha_pkg::ADDR_W-1:0] free_addr;
    logic [ffha_pkg::ADDR_W-1:0] free_diff;
    logic                        free_bad;

    // Word 0 is the only entry with a defined reset value; until it is written,
    // reads of it return the initial whole-heap block.
    assign size_rd = size_def_reg ? SIZE_RESET : size_q_reg;
    assign link_rd = link_def_reg ? NULL_LINK  : link_q_reg;

    // During a free, the merge check reads the successor right away.
    assign rd_idx = (state_reg == ST_F_EVAL) ? link_rd[AW-1:0] : cur_reg[AW-1:0];

    assign have_x       = XW'(size_rd);
    assign need_x       = XW'(need_reg);
    assign hdr_addr_x   = (XW'(cur_reg) << 2) + HDR_X;
    assign split_byte_x = hdr_addr_x + need_x;
    assign split_word_x = split_byte_x >> 2;
    assign end_byte_x   = hdr_addr_x + have_x;
    assign merge_sum_x  = XW'(hold_size_reg) + HDR_X + have_x;
    assign fits         = have_x >= need_x;
    assign can_split    = (have_x >= need_x + MIN_TAIL_X) && (split_word_x < WORDS_X);

    assign free_addr = s_tdata[ffha_pkg::ADDR_LSB +: ffha_pkg::ADDR_W];
    assign free_diff = free_addr - HDR_A;
    assign free_bad  = (free_addr < HDR_A) || (free_diff[1:0] != 2'b00)
                     || (XW'(free_diff[ffha_pkg::ADDR_W-1:2]) >= WORDS_X);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ffha_pkg::M_TDATA_W'(out_addr_reg);
    assign m_tuser  = out_ok_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        split_next     = split_reg;
        cnt_next       = cnt_reg;
        need_next      = need_reg;
        hold_size_next = hold_size_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        size_we        = 1'b0;
        size_wa        = cur_reg[AW-1:0];
        size_wd        = SW'(need_reg);
        link_we        = 1'b0;
        link_wa        = prev_reg[AW-1:0];
        link_wd        = link_rd;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cnt_next      = '0;
                    prev_next     = NULL_LINK;
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    need_next     = (ffha_pkg::NEED_W'(s_tdata[ffha_pkg::REQ_LSB +:
                                      ffha_pkg::REQ_W]) + ffha_pkg::NEED_W'(3))
                                    & ~ffha_pkg::NEED_W'(3);
                    if (s_tuser[0] == ffha_pkg::CMD_ALLOC)
                    begin
                        cur_next   = head_reg;
                        state_next = ST_A_READ;
                    end
                    else if (free_bad)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cur_next   = WW'(free_diff[ffha_pkg::ADDR_W-1:2]);
                        state_next = ST_F_PUSH;
                    end
                end
            end

            // Allocate: first-fit walk, one block per read.
            ST_A_READ:
            begin
                if (cnt_reg >= CNT_LIMIT || cur_reg >= NULL_LINK)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_A_EVAL;
                end
            end

            ST_A_EVAL:
            begin
                if (fits)
                begin
                    res_addr_next = hdr_addr_x[ffha_pkg::ADDR_W-1:0];
                    res_ok_next   = 1'b1;
                    if (can_split)
                    begin
                        // The tail becomes a new free block that inherits the link.
                        size_we    = 1'b1;
                        size_wa    = split_word_x[AW-1:0];
                        size_wd    = SW'(have_x - HDR_X - need_x);
                        link_we    = 1'b1;
                        link_wa    = split_word_x[AW-1:0];
                        link_wd    = link_rd;
                        split_next = split_word_x[WW-1:0];
                        state_next = ST_A_SPLIT;
                    end
                    else
                    begin
                        if (prev_reg == NULL_LINK)
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            link_we = 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_A_READ;
                end
            end

            ST_A_SPLIT:
            begin
                size_we = 1'b1;
                size_wa = cur_reg[AW-1:0];
                size_wd = SW'(need_reg);
                link_wd = split_reg;
                if (prev_reg == NULL_LINK)
                begin
                    head_next = split_reg;
                end
                else
                begin
                    link_we = 1'b1;
                end
                state_next = ST_RESP;
            end

            // Free: push at the head, then walk and coalesce adjacent successors.
            ST_F_PUSH:
            begin
                link_we    = 1'b1;
                link_wa    = cur_reg[AW-1:0];
                link_wd    = head_reg;
                head_next  = cur_reg;
                res_ok_next = 1'b1;
                state_next = ST_F_READ;
            end

            ST_F_READ:
            begin
                if (cnt_reg >= CNT_LIMIT || cur_reg >= NULL_LINK)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_F_EVAL;
                end
            end

            ST_F_EVAL:
            begin
                if (link_rd >= NULL_LINK)
                begin
                    state_next = ST_RESP;
                end
                else if (end_byte_x == (XW'(link_rd) << 2))
                begin
                    hold_size_next = size_rd;
                    state_next     = ST_F_MERGE;
                end
                else
                begin
                    cur_next   = link_rd;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_F_READ;
                end
            end

            ST_F_MERGE:
            begin
                // The read data now belongs to the successor block.
                size_we    = 1'b1;
                size_wa    = cur_reg[AW-1:0];
                size_wd    = (merge_sum_x > SIZE_MAX_X) ? SIZE_RESET : SW'(merge_sum_x);
                link_we    = 1'b1;
                link_wa    = cur_reg[AW-1:0];
                link_wd    = link_rd;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ST_F_READ;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        size0_ok_next = size0_ok_reg || (size_we && size_wa == '0);
        link0_ok_next = link0_ok_reg || (link_we && link_wa == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            size0_ok_reg  <= 1'b0;
            link0_ok_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            size0_ok_reg  <= size0_ok_next;
            link0_ok_reg  <= link0_ok_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        split_reg     <= split_next;
        need_reg      <= need_next;
        hold_size_reg <= hold_size_next;
        res_addr_reg  <= res_addr_next;
        res_ok_reg    <= res_ok_next;
        out_addr_reg  <= out_addr_next;
        out_ok_reg    <= out_ok_next;
    end

    always_ff @(posedge clk)
    begin
        size_q_reg   <= size_mem[rd_idx];
        link_q_reg   <= link_mem[rd_idx];
        size_def_reg <= (rd_idx == '0) && !size0_ok_reg;
        link_def_reg <= (rd_idx == '0) && !link0_ok_reg;
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
    end

    // A failed request never reports a nonzero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("failed request carries a nonzero address");

    // The step counter bounds every walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LIMIT)
        else $error("walk counter exceeded its limit");

    // The list head is always a heap word or the null link.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_LINK)
        else $error("list head outside the heap");

    // After a request is taken, the block is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a previous one is in progress");

endmodule
